// File: rtl/core/nsc_pkg.sv
// Package for the NAND ECC syndrome corrector: beat types, status codes,
// defaults for the top-level parameters. No dependencies.
`default_nettype none

package nsc_pkg;

   localparam int MAX_BLOCKS_DEF  = 8;
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam int SYN_W      = 24;
   localparam int POS_W      = 12;
   localparam int FIX_WEIGHT = 11;
   localparam logic [7:0] ERASED_BYTE = 8'hFF;

   localparam logic [2:0] ST_CLEAN  = 3'd0;
   localparam logic [2:0] ST_FIXED  = 3'd1;
   localparam logic [2:0] ST_FAIL   = 3'd2;
   localparam logic [2:0] ST_ERASED = 3'd3;
   localparam logic [2:0] ST_SKIP   = 3'd4;

   typedef struct packed {
      logic [7:0] stored_ecc_0;
      logic [7:0] stored_ecc_1;
      logic [7:0] stored_ecc_2;
      logic [7:0] calc_ecc_0;
      logic [7:0] calc_ecc_1;
      logic [7:0] calc_ecc_2;
      logic       last_block;
   } req_type;

   typedef struct packed {
      logic [2:0] block_number;
      logic       fix_valid;
      logic [8:0] fix_byte;
      logic [2:0] fix_bit;
      logic [2:0] block_status;
      logic       page_fail;
      logic       page_done;
   } rsp_type;

   // Classified block, as it sits in the queue
   typedef struct packed {
      logic             nonzero;
      logic             single;
      logic             erased;
      logic [POS_W-1:0] pos;
      logic             last;
   } cls_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

`default_nettype wire

// File: rtl/core/nand_ecc_syndrome_corrector.sv
// Top level of the NAND ECC syndrome corrector: front end, queue, back end.
// Depends on nsc_pkg, nsc_front, nsc_queue, nsc_back.
`default_nettype none

// Usage:
//   Send one req beat per 512-byte ECC block of a page: the three stored
//   ECC bytes from the spare area, the three computed ones, and last_block
//   on the final block of the page. Each req beat yields exactly one rsp
//   beat, in order: block index, fix position (byte offset, bit index)
//   when a single-bit error is found, block status and the sticky
//   page-fail flag. After an erased-page block the rest of the page is
//   reported as skipped.
//   Throughput: one block per cycle while req_stall and rsp_stall are low. An
//   accepted beat is first written into the queue, then loaded into the output
//   register in the back end, and only then offered on rsp.
//   The front end classifies each beat as it is taken and writes it to a
//   QUEUE_DEPTH-entry queue; req_stall rises only when that queue is full.
//   When rsp_stall is held, the output beat holds, the queue fills, and
//   up to QUEUE_DEPTH + 1 blocks are absorbed before req stalls.
//   Reset clears the queue, the output valid and the page state (block
//   index, fail and erased flags); the next beat starts a new page.

module nand_ecc_syndrome_corrector
   import nsc_pkg::*;
#(
   parameter int MAX_BLOCKS  = MAX_BLOCKS_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cls_type   cls;
   cls_type   head;
   qstat_type qstat;
   logic      push;
   logic      pop;

   // classify in the front end
   nsc_front u_front (
      .req (req_data),
      .cls (cls)
   );

   // hold classified blocks until the back end takes them
   assign req_stall = qstat.full;
   assign push      = req_valid && !qstat.full;

   nsc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (cls),
      .pop       (pop),
      .head      (head),
      .stat      (qstat)
   );

   // apply page state and drive the result beat
   nsc_back #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (!qstat.empty),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

`ifndef SYNTH
   a_fix_matches_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.fix_valid == (rsp_data.block_status == ST_FIXED)))
      else $error("fix_valid disagrees with block status");

   a_fail_is_sticky: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.block_status == ST_FAIL)) |-> rsp_data.page_fail)
      else $error("uncorrectable block without page fail");

   a_no_pos_unless_fix: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.fix_valid) |-> ((rsp_data.fix_byte == '0)
                                              && (rsp_data.fix_bit == '0)))
      else $error("fix position on a block without a fix");

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      pop |-> !qstat.empty)
      else $error("back end popped an empty queue");
`endif

endmodule

`default_nettype wire

// File: rtl/core/nsc_front.sv
// Front end: forms the 24-bit syndrome of one beat and classifies it.
// Depends on nsc_pkg.
`default_nettype none

module nsc_front
   import nsc_pkg::*;
(
   input  req_type req,
   output cls_type cls
);

   logic [SYN_W-1:0] syn;

   assign syn = {req.stored_ecc_2 ^ req.calc_ecc_2,
                 req.stored_ecc_1 ^ req.calc_ecc_1,
                 req.stored_ecc_0 ^ req.calc_ecc_0};

   always_comb begin
      cls.nonzero = |syn;
      cls.single  = ($countones(syn) == FIX_WEIGHT);
      cls.erased  = (req.stored_ecc_0 == ERASED_BYTE) && (req.stored_ecc_1 == ERASED_BYTE)
                    && (req.stored_ecc_2 == ERASED_BYTE);
      cls.last    = req.last_block;
      // gather odd syndrome bits; syndrome bit 23 lands at the top of pos
      for (int j = 0; j < POS_W; j++) begin
         cls.pos[j] = syn[2*j+1];
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/nsc_queue.sv
// Short queue of classified blocks between front and back end.
// Depends on nsc_pkg.
`default_nettype none

module nsc_queue
   import nsc_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
)(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  cls_type   push_data,
   input  logic      pop,
   output cls_type   head,
   output qstat_type stat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [PTR_W:0] FULL_CNT = (PTR_W+1)'(DEPTH);

   cls_type          entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      bump = (p == PTR_W'(DEPTH-1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head       = entries_ff[rd_ptr_ff];
   assign stat.full  = (count_ff == FULL_CNT);
   assign stat.empty = (count_ff == '0);

endmodule

`default_nettype wire

// File: rtl/core/nsc_back.sv
// Back end: applies page state to queued blocks and holds the result beat.
// Depends on nsc_pkg.
`default_nettype none

module nsc_back
   import nsc_pkg::*;
#(
   parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
)(
   input  logic    clock,
   input  logic    reset,
   input  logic    head_valid,
   input  cls_type head,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int CNT_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             fail_ff, fail_in;
   logic             halt_ff, halt_in;
   logic             valid_ff, valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic [CNT_W+2:0] cnt_ext;

   // load when the output register is free or being drained
   assign pop = head_valid && (!valid_ff || !rsp_stall);
   assign cnt_ext = {3'b000, cnt_ff};

   always_comb begin
      fail_in  = fail_ff;
      halt_in  = halt_ff;
      cnt_in   = cnt_ff;
      valid_in = valid_ff;
      rsp_in   = rsp_ff;
      if (pop) begin
         valid_in            = 1'b1;
         rsp_in.fix_valid    = 1'b0;
         rsp_in.fix_byte     = '0;
         rsp_in.fix_bit      = '0;
         rsp_in.block_status = ST_CLEAN;
         if (halt_ff) begin
            rsp_in.block_status = ST_SKIP;
         end else if (head.nonzero) begin
            if (head.single) begin
               rsp_in.fix_valid    = 1'b1;
               rsp_in.fix_byte     = head.pos[POS_W-1:3];
               rsp_in.fix_bit      = head.pos[2:0];
               rsp_in.block_status = ST_FIXED;
            end else if (head.erased) begin
               halt_in             = 1'b1;
               rsp_in.block_status = ST_ERASED;
            end else begin
               fail_in             = 1'b1;
               rsp_in.block_status = ST_FAIL;
            end
         end
         rsp_in.block_number = cnt_ext[2:0];
         rsp_in.page_fail    = fail_in;
         rsp_in.page_done    = head.last;
         // advance or restart the page
         if (head.last) begin
            cnt_in  = '0;
            fail_in = 1'b0;
            halt_in = 1'b0;
         end else if (cnt_ff == CNT_W'(MAX_BLOCKS-1)) begin
            cnt_in = '0;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         fail_ff  <= 1'b0;
         halt_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         fail_ff  <= fail_in;
         halt_ff  <= halt_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// File: bench/nand_ecc_syndrome_corrector_test.sv
// Self-checking bench for nand_ecc_syndrome_corrector: directed table of ECC
// blocks, then random pages, checked by a built-in predictor or typed-in results.
// Depends on nsc_pkg and the nand_ecc_syndrome_corrector RTL.
`timescale 1ns / 1ps

module nand_ecc_syndrome_corrector_test;
   import nsc_pkg::*;

   localparam int HALF_PERIOD  = 10;
   localparam int RESET_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int DRAIN_CYCLES = 6;
   localparam int HOLD_OFF_LEN = 60;
   localparam int REPORT_MAX   = 10;

   // One row of the directed table; pinned rows carry a typed-in result
   typedef struct {
      req_type req;
      bit      pinned;
      rsp_type want;
   } block_row_type;

   logic    clock          = 1'b0;
   logic    reset          = 1'b1;
   logic    req_valid      = 1'b0;
   logic    req_stall;
   req_type req_data       = '0;
   logic    rsp_valid;
   logic    rsp_stall      = 1'b0;
   rsp_type rsp_data;

   // Bench-side companions of the req beat, driven along with req_data
   bit      req_pinned     = 1'b0;
   rsp_type req_pinned_rsp = '0;

   block_row_type directed_rows[$];
   rsp_type       pending_results[$];

   // Predictor copy of the page state
   int unsigned page_block_idx = 0;
   bit          page_failed    = 1'b0;
   bit          page_halted    = 1'b0;

   int  cycle_count      = 0;
   int  mismatch_count   = 0;
   int  blocks_offered   = 0;
   int  send_idle_pct    = 17;
   int  recv_stall_pct   = 70;
   int  hold_left        = 0;
   bit  hold_off_request = 1'b0;
   bit  hold_off_served  = 1'b0;
   bit  timed_out        = 1'b0;

   rsp_type want_block;
   rsp_type got_block;

   nand_ecc_syndrome_corrector i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // Work out the result of one block and advance the page state.
   function automatic rsp_type predict_block(req_type blk);
      logic [SYN_W-1:0] syn;
      logic [POS_W-1:0] pos;
      rsp_type          res;
      int               k;
      syn = {blk.stored_ecc_2 ^ blk.calc_ecc_2,
             blk.stored_ecc_1 ^ blk.calc_ecc_1,
             blk.stored_ecc_0 ^ blk.calc_ecc_0};
      res = '0;
      res.block_number = page_block_idx[2:0];
      res.block_status = ST_CLEAN;
      if (page_halted) begin
         res.block_status = ST_SKIP;
      end else if (syn != '0) begin
         if ($countones(syn) == FIX_WEIGHT) begin
            // gather the odd syndrome bits, bit 23 ends up as the top of pos
            for (k = 0; k < POS_W; k++)
               pos[k] = syn[2 * k + 1];
            res.fix_valid    = 1'b1;
            res.fix_byte     = pos[POS_W-1:3];
            res.fix_bit      = pos[2:0];
            res.block_status = ST_FIXED;
         end else if (blk.stored_ecc_0 == ERASED_BYTE && blk.stored_ecc_1 == ERASED_BYTE &&
                      blk.stored_ecc_2 == ERASED_BYTE) begin
            page_halted      = 1'b1;
            res.block_status = ST_ERASED;
         end else begin
            page_failed      = 1'b1;
            res.block_status = ST_FAIL;
         end
      end
      res.page_fail = page_failed;
      res.page_done = blk.last_block;
      if (blk.last_block) begin
         page_block_idx = 0;
         page_failed    = 1'b0;
         page_halted    = 1'b0;
      end else begin
         page_block_idx = (page_block_idx + 1) % MAX_BLOCKS_DEF;
      end
      return res;
   endfunction

   // Build a syndrome of weight 11 whose odd bits spell pos; pad with random even bits.
   function automatic logic [SYN_W-1:0] fixable_syndrome(logic [POS_W-1:0] pos);
      logic [SYN_W-1:0] syn;
      int               need;
      int               j;
      if (pos == '1)
         pos[0] = 1'b0;   // twelve odd ones would already exceed the weight
      syn = '0;
      for (j = 0; j < POS_W; j++)
         syn[2 * j + 1] = pos[j];
      need = FIX_WEIGHT - $countones(pos);
      while (need > 0) begin
         j = $urandom_range(POS_W - 1);
         if (!syn[2 * j]) begin
            syn[2 * j] = 1'b1;
            need--;
         end
      end
      return syn;
   endfunction

   function automatic string block_text(rsp_type b);
      return $sformatf("blk %0d fix %0d byte %0d bit %0d status %0d fail %0d done %0d",
                       b.block_number, b.fix_valid, b.fix_byte, b.fix_bit,
                       b.block_status, b.page_fail, b.page_done);
   endfunction

   function automatic void add_row(req_type blk, bit pinned, rsp_type want);
      block_row_type row;
      row.req    = blk;
      row.pinned = pinned;
      row.want   = want;
      directed_rows.push_back(row);
   endfunction

   task automatic note_mismatch(string what, rsp_type want, rsp_type got);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
         $display("%0t: %s: expected %s, got %s", $time, what,
                  block_text(want), block_text(got));
   endtask

   // Offer one beat on req: random idle cycles first, then hold until taken.
   task automatic offer_block(req_type blk, bit pinned, rsp_type want);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_data       <= blk;
      req_pinned     <= pinned;
      req_pinned_rsp <= want;
      do
         @(posedge clock);
      while (req_stall);
      blocks_offered++;
   endtask

   // One page of random blocks; now and then longer than MAX_BLOCKS to force a wrap.
   task automatic random_page();
      int               n_blocks;
      int               i;
      int               kind;
      req_type          blk;
      logic [SYN_W-1:0] syn;
      n_blocks = ($urandom_range(9) == 0) ? $urandom_range(12, 9) : $urandom_range(8, 1);
      for (i = 0; i < n_blocks; i++) begin
         blk.stored_ecc_0 = 8'($urandom_range(255));
         blk.stored_ecc_1 = 8'($urandom_range(255));
         blk.stored_ecc_2 = 8'($urandom_range(255));
         // blank spare area: erased-page candidate
         if ($urandom_range(99) < 20) begin
            blk.stored_ecc_0 = ERASED_BYTE;
            blk.stored_ecc_1 = ERASED_BYTE;
            blk.stored_ecc_2 = ERASED_BYTE;
         end
         kind = $urandom_range(99);
         if (kind < 35)
            syn = fixable_syndrome(POS_W'($urandom_range(4095)));
         else if (kind < 50)
            syn = '0;
         else
            syn = SYN_W'($urandom);
         blk.calc_ecc_0 = blk.stored_ecc_0 ^ syn[7:0];
         blk.calc_ecc_1 = blk.stored_ecc_1 ^ syn[15:8];
         blk.calc_ecc_2 = blk.stored_ecc_2 ^ syn[23:16];
         blk.last_block = (i == n_blocks - 1);
         offer_block(blk, 1'b0, '0);
      end
   endtask

   // Receiver: random stall, plus one long hold-off when asked for.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_off_request && !hold_off_served) begin
            hold_left       = HOLD_OFF_LEN;
            hold_off_served = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   // Predict each accepted req beat, check each accepted rsp beat in order.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            want_block = predict_block(req_data);
            if (req_pinned)
               want_block = req_pinned_rsp;
            pending_results.push_back(want_block);
         end
         if (rsp_valid && !rsp_stall) begin
            got_block = rsp_data;
            if (pending_results.size() == 0) begin
               note_mismatch("unexpected beat", '0, got_block);
            end else begin
               want_block = pending_results.pop_front();
               if (got_block.block_number !== want_block.block_number ||
                   got_block.fix_valid    !== want_block.fix_valid    ||
                   got_block.fix_byte     !== want_block.fix_byte     ||
                   got_block.fix_bit      !== want_block.fix_bit      ||
                   got_block.block_status !== want_block.block_status ||
                   got_block.page_fail    !== want_block.page_fail    ||
                   got_block.page_done    !== want_block.page_done)
                  note_mismatch("mismatch", want_block, got_block);
            end
         end
      end
   end

   initial begin
      // Page A: clean, fix at the top position, failure, fix at position zero with
      // blank stored ECC, blank stored ECC with zero syndrome, clean last block.
      add_row(req_type'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b1,
              rsp_type'{3'd0, 1'b0, 9'd0, 3'd0, ST_CLEAN, 1'b0, 1'b0});
      add_row(req_type'{8'h00, 8'h00, 8'h00, 8'hA8, 8'hAA, 8'hAA, 1'b0}, 1'b1,
              rsp_type'{3'd1, 1'b1, 9'd511, 3'd6, ST_FIXED, 1'b0, 1'b0});
      add_row(req_type'{8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b1,
              rsp_type'{3'd2, 1'b0, 9'd0, 3'd0, ST_FAIL, 1'b1, 1'b0});
      add_row(req_type'{8'hFF, 8'hFF, 8'hFF, 8'hAB, 8'hAA, 8'hAA, 1'b0}, 1'b1,
              rsp_type'{3'd3, 1'b1, 9'd0, 3'd0, ST_FIXED, 1'b1, 1'b0});
      add_row(req_type'{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0}, 1'b1,
              rsp_type'{3'd4, 1'b0, 9'd0, 3'd0, ST_CLEAN, 1'b1, 1'b0});
      add_row(req_type'{8'h5A, 8'hA5, 8'h3C, 8'h5A, 8'hA5, 8'h3C, 1'b1}, 1'b1,
              rsp_type'{3'd5, 1'b0, 9'd0, 3'd0, ST_CLEAN, 1'b1, 1'b1});
      // Page B: failure, then an erased page keeps the fail flag and skips the rest
      add_row(req_type'{8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b0}, 1'b1,
              rsp_type'{3'd0, 1'b0, 9'd0, 3'd0, ST_FAIL, 1'b1, 1'b0});
      add_row(req_type'{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b1,
              rsp_type'{3'd1, 1'b0, 9'd0, 3'd0, ST_ERASED, 1'b1, 1'b0});
      add_row(req_type'{8'h00, 8'h00, 8'h00, 8'hA8, 8'hAA, 8'hAA, 1'b0}, 1'b1,
              rsp_type'{3'd2, 1'b0, 9'd0, 3'd0, ST_SKIP, 1'b1, 1'b0});
      add_row(req_type'{8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1}, 1'b1,
              rsp_type'{3'd3, 1'b0, 9'd0, 3'd0, ST_SKIP, 1'b1, 1'b1});
      // Page C: erased on the first block, flags cleared by the previous page end
      add_row(req_type'{8'hFF, 8'hFF, 8'hFF, 8'hFE, 8'hFF, 8'hFF, 1'b0}, 1'b1,
              rsp_type'{3'd0, 1'b0, 9'd0, 3'd0, ST_ERASED, 1'b0, 1'b0});
      add_row(req_type'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1}, 1'b1,
              rsp_type'{3'd1, 1'b0, 9'd0, 3'd0, ST_SKIP, 1'b0, 1'b1});
      // Page D: ten blocks, the counter wraps past MAX_BLOCKS with the fail flag kept
      add_row(req_type'{8'h12, 8'h34, 8'h56, 8'h38, 8'h61, 8'h03, 1'b0}, 1'b0, '0);
      add_row(req_type'{8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b0, '0);
      add_row(req_type'{8'h00, 8'h00, 8'h80, 8'h7F, 8'hFF, 8'h7F, 1'b0}, 1'b0, '0);
      add_row(req_type'{8'h00, 8'h00, 8'h00, 8'h56, 8'h55, 8'h85, 1'b0}, 1'b0, '0);
      add_row(req_type'{8'hC3, 8'h3C, 8'h99, 8'hC3, 8'h3C, 8'h99, 1'b0}, 1'b0, '0);
      add_row(req_type'{8'hFF, 8'hFF, 8'hFE, 8'hFF, 8'hFF, 8'hFE, 1'b0}, 1'b0, '0);
      add_row(req_type'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b0, '0);
      add_row(req_type'{8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 1'b0}, 1'b0, '0);
      add_row(req_type'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b1,
              rsp_type'{3'd0, 1'b0, 9'd0, 3'd0, ST_CLEAN, 1'b1, 1'b0});
      add_row(req_type'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1}, 1'b1,
              rsp_type'{3'd1, 1'b0, 9'd0, 3'd0, ST_CLEAN, 1'b1, 1'b1});

      // Hold reset, release on a falling edge
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      fork
         begin
            foreach (directed_rows[i])
               offer_block(directed_rows[i].req, directed_rows[i].pinned,
                           directed_rows[i].want);
            // sender mostly busy, receiver mostly stalled
            while (blocks_offered < 580)
               random_page();
            // swap: sender sparse, receiver mostly ready
            send_idle_pct  = 70;
            recv_stall_pct = 17;
            while (blocks_offered < 1140)
               random_page();
            // full rate both ways, with one long receiver hold-off to back up req
            send_idle_pct    = 0;
            recv_stall_pct   = 0;
            hold_off_request = 1'b1;
            while (blocks_offered < 1700)
               random_page();
            @(negedge clock);
            req_valid <= 1'b0;
            // drain, then keep watching for stray beats
            while (pending_results.size() != 0)
               @(posedge clock);
            repeat (DRAIN_CYCLES) @(posedge clock);
         end
         begin
            wait (cycle_count >= CYCLE_LIMIT);
            timed_out = 1'b1;
         end
      join_any

      if (timed_out) begin
         $display("nand_ecc_syndrome_corrector verification failed");
      end else if (mismatch_count == 0) begin
         $display("nand_ecc_syndrome_corrector verification clean");
      end else begin
         $display("nand_ecc_syndrome_corrector verification failed");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/core/nsc_pkg.sv
rtl/core/nsc_front.sv
rtl/core/nsc_queue.sv
rtl/core/nsc_back.sv
rtl/core/nand_ecc_syndrome_corrector.sv
bench/nand_ecc_syndrome_corrector_test.sv
